[sv/hbmc_pkg.sv]
// shared constants, codes and types for the h-bridge motor command block
`default_nettype none

package hbmc_pkg;

  localparam int MOTOR_COUNT = 3;
  localparam int DUTY_MAX    = 1023;
  localparam int PCT_MAX     = 100;

  localparam int MOTOR_W = 2;
  localparam int PCT_W   = 8;
  localparam int DUR_W   = 32;
  localparam int DUTY_W  = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 3;
  localparam int CIDX_W  = 2;

  localparam int MI_W    = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int MAG_W   = $clog2(PCT_MAX + 1);

  // duty = mag * DUTY_MAX / 100 as one multiply by a scaled reciprocal of 100
  localparam int RECIP_SH   = 19;
  localparam int DUTY_RECIP = (1 << RECIP_SH) / PCT_MAX + 1;
  localparam int DUTY_SCALE = DUTY_MAX * DUTY_RECIP;
  localparam int PROD_W     = $clog2(PCT_MAX * DUTY_SCALE + 1);

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_STOP  = 3'd1,
    OP_BRAKE = 3'd2,
    OP_TIMED = 3'd3,
    OP_TICK  = 3'd4,
    OP_GUARD = 3'd5
  } op_t;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_MOTOR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAFETY    = 2'd2;

  localparam logic [CIDX_W-1:0] REG_DIR_MASK   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_BRAKE_MASK = 2'd1;
  localparam logic [CIDX_W-1:0] REG_INV_MASK   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_ZERO_BRAKE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SWEEP,
    S_OUT
  } state_t;

  typedef enum logic {
    SW_ZERO,
    SW_CAP
  } sweep_t;

endpackage

`default_nettype wire

[sv/hbmc_duty.sv]
// duty unit: magnitude times full duty over 100 by a reciprocal multiply
`default_nettype none

module hbmc_duty import hbmc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [MAG_W-1:0]  mag,
  output logic                   done,
  output logic [DUTY_W-1:0]      duty
);

  logic [MAG_W-1:0]  mag_q;
  logic              busy;
  logic [PROD_W-1:0] prod;

  always_comb begin
    prod = PROD_W'(mag_q) * PROD_W'(DUTY_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) mag_q <= mag;
    if (busy)  duty  <= prod[RECIP_SH +: DUTY_W];
  end

endmodule

`default_nettype wire

[sv/h_bridge_motor_command.sv]
// top level: command sequencer, channel state and config registers of the h-bridge block
//
// One input beat on s_* carries a command; op travels in s_tuser. Result beats leave
// on m_* with m_tlast on the final beat of a command. The block takes one command at a
// time: s_tready is high only while no command is in progress.
// Set speed gives one beat. A nonzero accepted speed that differs from the stored one
// runs the duty unit, a reciprocal multiply, and its beat is registered after the
// duty result; every other set-speed answer appears in the cycle after acceptance.
// Stop all, brake all, timed brake, a releasing tick and a tripped guard check give one
// beat per motor; each later beat is built in the sweep state after the last was taken.
// A tick that does not release, a guard check with nothing to do and unused ops give
// no beat; the block is ready again on the next cycle.
// When the receiver holds m_tready low the current beat stays in the output register
// and the sequence pauses until it is taken.
// Reset (rst, synchronous) stops all motors in the stored state, disarms the release
// timer and loads the config registers with their defaults. cfg_we writes register
// cfg_index from cfg_data.
`default_nettype none

module h_bridge_motor_command import hbmc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [47:0]       s_tdata,   // motor, percent, brake_ticks, safety_ok, distance_limit
  input  wire logic [2:0]        s_tuser,   // op
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata,   // motor_index, updated, pin_a, pin_b, duty, status
  output logic                   m_tlast,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [MOTOR_COUNT-1:0] dir_mask, brake_mask, inv_mask;
  logic                   zero_brake;

  logic signed [PCT_W-1:0] speed [MOTOR_COUNT];
  logic signed [PCT_W-1:0] speed_next [MOTOR_COUNT];
  logic [DUR_W-1:0]        count, count_next;
  logic                    armed, armed_next;

  logic [MI_W-1:0]         idx, idx_next;
  sweep_t                  kind, kind_next;
  logic                    lv, lv_next;

  logic [MOTOR_W-1:0]      o_motor, o_motor_next;
  logic                    o_upd, o_upd_next;
  logic                    o_a, o_a_next;
  logic                    o_b, o_b_next;
  logic [DUTY_W-1:0]       o_duty, o_duty_next;
  logic [STAT_W-1:0]       o_status, o_status_next;
  logic                    o_last, o_last_next;

  logic                    duty_start;
  logic                    duty_done;
  logic [DUTY_W-1:0]       duty_q;
  logic [MAG_W-1:0]        mag;

  op_t                     op_in;
  logic [MOTOR_W-1:0]      m_in;
  logic signed [PCT_W-1:0] p_raw, p_c, cur_spd;
  logic [DUR_W-1:0]        dur_in;
  logic                    safe_in, dist_in;
  logic [MOTOR_COUNT-1:0]  sel_m, cap_mask;
  logic                    m_ok, dir_m, cap_m, inv_m, neg, running;
  logic [DUR_W-1:0]        count_dec;
  logic                    cap_i;

  hbmc_duty u_duty (
    .clk   (clk),
    .rst   (rst),
    .start (duty_start),
    .mag   (mag),
    .done  (duty_done),
    .duty  (duty_q)
  );

  // decode of the incoming beat
  always_comb begin
    op_in   = op_t'(s_tuser);
    m_in    = s_tdata[1:0];
    p_raw   = s_tdata[9:2];
    dur_in  = s_tdata[41:10];
    safe_in = s_tdata[42];
    dist_in = s_tdata[43];

    cap_mask = dir_mask & brake_mask;
    sel_m    = MOTOR_COUNT'(1) << m_in;
    m_ok     = (32'(m_in) < MOTOR_COUNT);
    dir_m    = |(dir_mask & sel_m);
    cap_m    = |(cap_mask & sel_m);
    inv_m    = |(inv_mask & sel_m);

    cur_spd = '0;
    running = 1'b0;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      if (sel_m[i]) cur_spd = speed[i];
      if (speed[i] != 0) running = 1'b1;
    end

    if (!dir_m && p_raw < 0) p_c = '0;
    else                     p_c = p_raw;
    if (p_c > PCT_W'(PCT_MAX))        p_c = PCT_W'(PCT_MAX);
    else if (p_c < -PCT_W'(PCT_MAX))  p_c = -PCT_W'(PCT_MAX);

    mag = (p_c < 0) ? MAG_W'(-p_c) : MAG_W'(p_c);
    neg = (p_c < 0) ^ inv_m;

    count_dec = (count != '0) ? count - DUR_W'(1) : count;
    cap_i     = cap_mask[idx];
  end

  always_comb begin
    state_next    = state;
    speed_next    = speed;
    count_next    = count;
    armed_next    = armed;
    idx_next      = idx;
    kind_next     = kind;
    lv_next       = lv;
    o_motor_next  = o_motor;
    o_upd_next    = o_upd;
    o_a_next      = o_a;
    o_b_next      = o_b;
    o_duty_next   = o_duty;
    o_status_next = o_status;
    o_last_next   = o_last;
    duty_start    = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          o_motor_next  = m_in;
          o_upd_next    = 1'b0;
          o_a_next      = 1'b0;
          o_b_next      = 1'b0;
          o_duty_next   = '0;
          o_status_next = STAT_OK;
          o_last_next   = 1'b1;
          case (op_in)
            OP_SET: begin
              state_next = S_OUT;
              if (!m_ok) begin
                o_status_next = STAT_BAD_MOTOR;
              end else if (p_c != 0 && !safe_in) begin
                o_status_next = STAT_SAFETY;
              end else if (p_c != 0 && cur_spd == p_c) begin
                o_status_next = STAT_OK;
              end else if (p_c == 0) begin
                o_upd_next = 1'b1;
                if (cap_m) begin
                  o_a_next    = zero_brake;
                  o_b_next    = zero_brake;
                  o_duty_next = DUTY_W'(DUTY_MAX);
                end
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                  if (sel_m[i]) speed_next[i] = '0;
                end
              end else begin
                if (cap_m) armed_next = 1'b0;
                o_upd_next = 1'b1;
                o_a_next   = dir_m & !neg;
                o_b_next   = dir_m & neg;
                for (int i = 0; i < MOTOR_COUNT; i++) begin
                  if (sel_m[i]) speed_next[i] = p_c;
                end
                duty_start = 1'b1;
                state_next = S_DIV;
              end
            end
            OP_STOP: begin
              idx_next   = '0;
              kind_next  = SW_ZERO;
              state_next = S_SWEEP;
            end
            OP_BRAKE: begin
              armed_next = 1'b0;
              idx_next   = '0;
              kind_next  = SW_CAP;
              lv_next    = 1'b1;
              state_next = S_SWEEP;
            end
            OP_TIMED: begin
              armed_next = (dur_in != '0);
              if (dur_in != '0) count_next = dur_in;
              idx_next   = '0;
              kind_next  = SW_CAP;
              lv_next    = 1'b1;
              state_next = S_SWEEP;
            end
            OP_TICK: begin
              if (armed) begin
                count_next = count_dec;
                if (count_dec == '0) begin
                  armed_next = 1'b0;
                  idx_next   = '0;
                  kind_next  = SW_CAP;
                  lv_next    = 1'b0;
                  state_next = S_SWEEP;
                end
              end
            end
            OP_GUARD: begin
              if (running && !safe_in) begin
                idx_next   = '0;
                state_next = S_SWEEP;
                if (dist_in) begin
                  armed_next = 1'b0;
                  kind_next  = SW_CAP;
                  lv_next    = 1'b1;
                end else begin
                  kind_next  = SW_ZERO;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (duty_done) begin
          o_duty_next = duty_q;
          state_next  = S_OUT;
        end
      end
      S_SWEEP: begin
        o_motor_next  = MOTOR_W'(idx);
        o_status_next = STAT_OK;
        o_last_next   = (idx == MI_W'(MOTOR_COUNT - 1));
        o_upd_next    = 1'b0;
        o_a_next      = 1'b0;
        o_b_next      = 1'b0;
        o_duty_next   = '0;
        if (kind == SW_ZERO) begin
          o_upd_next = 1'b1;
          if (cap_i) begin
            o_a_next    = zero_brake;
            o_b_next    = zero_brake;
            o_duty_next = DUTY_W'(DUTY_MAX);
          end
          speed_next[idx] = '0;
        end else if (cap_i) begin
          o_upd_next      = 1'b1;
          o_a_next        = lv;
          o_b_next        = lv;
          o_duty_next     = DUTY_W'(DUTY_MAX);
          speed_next[idx] = '0;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) begin
          if (o_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + MI_W'(1);
            state_next = S_SWEEP;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) speed[i] <= '0;
      count <= '0;
      armed <= 1'b0;
      idx   <= '0;
      kind  <= SW_ZERO;
      lv    <= 1'b0;
    end else begin
      speed <= speed_next;
      count <= count_next;
      armed <= armed_next;
      idx   <= idx_next;
      kind  <= kind_next;
      lv    <= lv_next;
    end
  end

  always_ff @(posedge clk) begin
    o_motor  <= o_motor_next;
    o_upd    <= o_upd_next;
    o_a      <= o_a_next;
    o_b      <= o_b_next;
    o_duty   <= o_duty_next;
    o_status <= o_status_next;
    o_last   <= o_last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_mask   <= MOTOR_COUNT'(3);
      brake_mask <= MOTOR_COUNT'(3);
      inv_mask   <= '0;
      zero_brake <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIR_MASK:   dir_mask   <= MOTOR_COUNT'(cfg_data);
        REG_BRAKE_MASK: brake_mask <= MOTOR_COUNT'(cfg_data);
        REG_INV_MASK:   inv_mask   <= MOTOR_COUNT'(cfg_data);
        REG_ZERO_BRAKE: zero_brake <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = o_last;
  assign m_tdata  = {7'b0, o_status, o_duty, o_b, o_a, o_upd, o_motor};

endmodule

`default_nettype wire
